// ===== rtl/btb_pkg.sv =====
// Shared types, constants and codes for the branch target buffer.
`timescale 1ns / 1ps
package btb_pkg;

	localparam int DEF_MAX_ENTRIES = 32;
	localparam int DEF_MAX_HISTORY = 8;
	localparam int ADDR_BITS = 32;
	localparam int TAG_W = 30;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 5;

	localparam int ROW_LSB = 2;
	localparam int SHARE_LOW_LSB = 2;
	localparam int SHARE_HIGH_LSB = 16;
	localparam int PC_STEP = 4;

	localparam logic [1:0] CTR_MAX = 2'd3;
	localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;

	localparam logic [2:0] RST_LOG2_ENTRIES = 3'd5;
	localparam logic [3:0] RST_HISTORY_BITS = 4'd8;
	localparam logic [4:0] RST_TAG_BITS = 5'd25;
	localparam logic [1:0] RST_INITIAL_STATE = 2'd1;

	localparam logic FUNC_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		REG_LOG2_ENTRIES,
		REG_HISTORY_BITS,
		REG_TAG_BITS,
		REG_INITIAL_STATE,
		REG_GLOBAL_HISTORY,
		REG_GLOBAL_TABLE,
		REG_SHARE_MODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SHARE_NONE,
		SHARE_PC_LOW,
		SHARE_PC_HIGH
	} share_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_CTR,
		S_FILL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic ctr_rd;
		logic commit;
		logic fill;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_fill;
		logic fill_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/btb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module btb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/btb_ctrl.sv =====
// Sequencing state machine for the branch target buffer.
`timescale 1ns / 1ps
module btb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  btb_pkg::status_t st,
	output btb_pkg::cmd_t    cmd
);

	btb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			btb_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = btb_pkg::S_ROW;
				end
			end
			btb_pkg::S_ROW: begin
				cmd.ctr_rd = 1'b1;
				state_d = btb_pkg::S_CTR;
			end
			btb_pkg::S_CTR: begin
				cmd.commit = 1'b1;
				state_d = st.need_fill ? btb_pkg::S_FILL : btb_pkg::S_DONE;
			end
			btb_pkg::S_FILL: begin
				cmd.fill = 1'b1;
				if (st.fill_last) begin
					state_d = btb_pkg::S_DONE;
				end
			end
			btb_pkg::S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = btb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = btb_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/btb_dp.sv =====
// Datapath of the branch target buffer: configuration, row store, counters and result register.
`timescale 1ns / 1ps
module btb_dp #(
	parameter int MAX_ENTRIES = btb_pkg::DEF_MAX_ENTRIES,
	parameter int MAX_HISTORY = btb_pkg::DEF_MAX_HISTORY
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [btb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [btb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           func,
	input  logic [31:0]                    pc,
	input  logic [31:0]                    resolved_pc,
	input  logic                           taken,
	input  logic [31:0]                    guessed_dst,
	input  btb_pkg::cmd_t                  cmd,
	output btb_pkg::status_t               st,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           predict_taken,
	output logic [31:0]                    next_pc,
	output logic [31:0]                    branch_count,
	output logic [31:0]                    flush_count
);

	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LE_MAX = $clog2(MAX_ENTRIES + 1) - 1;
	localparam int HW = MAX_HISTORY;
	localparam int CTR_DEPTH = 1 << HW;
	localparam int CW = RW + HW;
	localparam int ROW_W = btb_pkg::TAG_W + btb_pkg::ADDR_BITS + HW;

	logic [2:0] log2_entries_q;
	logic [3:0] history_bits_q;
	logic [4:0] tag_bits_q;
	logic [1:0] initial_state_q;
	logic       global_history_q;
	logic       global_table_q;
	logic [1:0] share_mode_q;

	logic [MAX_ENTRIES-1:0] row_valid_q;
	logic [CTR_DEPTH-1:0]   sh_valid_q;
	logic [HW-1:0]          shist_q;
	logic [31:0]            upd_q;
	logic [31:0]            mis_q;

	logic        func_q;
	logic [31:0] pc_q;
	logic [31:0] target_q;
	logic        taken_q;
	logic        ok_q;
	logic [RW-1:0] row_q;

	logic                          hit_s2;
	logic [HW-1:0]                 idx_s2;
	logic [HW-1:0]                 hist_s2;
	logic [HW-1:0]                 rowh_s2;
	logic [btb_pkg::TAG_W-1:0]     tag_s2;
	logic [31:0]                   tgt_s2;

	logic [HW-1:0] fill_q;
	logic          res_taken_q;
	logic [31:0]   res_pc_q;

	logic          out_valid_q;
	logic          out_taken_q;
	logic [31:0]   out_pc_q;
	logic [31:0]   out_bc_q;
	logic [31:0]   out_fc_q;

	logic [2:0]  eff_le;
	logic [3:0]  eff_h;
	logic [4:0]  tag_n;
	logic [HW-1:0] hmask;
	logic [RW-1:0] rmask;
	logic [btb_pkg::TAG_W-1:0] tmask;
	logic [RW-1:0] row_in;
	logic [3:0]  tag_shift;
	logic [btb_pkg::TAG_W-1:0] pc_tag;

	logic [ROW_W-1:0] row_rd;
	logic [btb_pkg::TAG_W-1:0] rd_tag;
	logic [31:0] rd_tgt;
	logic [HW-1:0] rd_hist;
	logic hit;
	logic [HW-1:0] hist_eff;
	logic [HW-1:0] share_x;
	logic [HW-1:0] idx;

	logic [1:0] sh_rd;
	logic [1:0] rc_rd;
	logic       upd;
	logic       need_fill;
	logic [1:0] ctr_old;
	logic [1:0] stepped;
	logic [HW:0] hist_shift;
	logic [HW-1:0] nh;
	logic [HW-1:0] row_hist_new;
	logic pred;

	logic          rc_we;
	logic [CW-1:0] rc_waddr;
	logic [1:0]    rc_wdata;
	logic          row_we;
	logic          sh_we;

	always_comb begin
		if (int'(log2_entries_q) > LE_MAX) begin
			eff_le = 3'(LE_MAX);
		end else begin
			eff_le = log2_entries_q;
		end
		if (history_bits_q == 4'd0) begin
			eff_h = 4'd1;
		end else if (int'(history_bits_q) > HW) begin
			eff_h = 4'(HW);
		end else begin
			eff_h = history_bits_q;
		end
		tag_n = (tag_bits_q > 5'(btb_pkg::TAG_W)) ? 5'(btb_pkg::TAG_W) : tag_bits_q;
		for (int i = 0; i < HW; i++) begin
			hmask[i] = (i < int'(eff_h));
		end
		for (int i = 0; i < RW; i++) begin
			rmask[i] = (i < int'(eff_le));
		end
		for (int i = 0; i < btb_pkg::TAG_W; i++) begin
			tmask[i] = (i < int'(tag_n));
		end
	end

	assign row_in = RW'(pc >> btb_pkg::ROW_LSB) & rmask;
	assign tag_shift = {1'b0, eff_le} + 4'(btb_pkg::ROW_LSB);
	assign pc_tag = btb_pkg::TAG_W'(pc_q >> tag_shift) & tmask;

	assign rd_tag = row_rd[ROW_W-1 -: btb_pkg::TAG_W];
	assign rd_tgt = row_rd[HW +: 32];
	assign rd_hist = row_rd[HW-1:0];
	assign hit = row_valid_q[row_q] && (rd_tag == pc_tag);

	always_comb begin
		case (share_mode_q)
			btb_pkg::SHARE_PC_LOW:  share_x = pc_q[btb_pkg::SHARE_LOW_LSB +: HW];
			btb_pkg::SHARE_PC_HIGH: share_x = pc_q[btb_pkg::SHARE_HIGH_LSB +: HW];
			default:                share_x = '0;
		endcase
	end

	assign hist_eff = (global_history_q ? shist_q : (hit ? rd_hist : '0)) & hmask;
	assign idx = (hist_eff ^ share_x) & hmask;

	assign upd = (func_q == btb_pkg::FUNC_UPDATE);
	assign need_fill = upd && !hit_s2 && !global_table_q;

	always_comb begin
		if (need_fill) begin
			ctr_old = initial_state_q;
		end else if (global_table_q) begin
			ctr_old = sh_valid_q[idx_s2] ? sh_rd : initial_state_q;
		end else begin
			ctr_old = rc_rd;
		end
		if (taken_q) begin
			stepped = (ctr_old == btb_pkg::CTR_MAX) ? ctr_old : ctr_old + 2'd1;
		end else begin
			stepped = (ctr_old == 2'd0) ? ctr_old : ctr_old - 2'd1;
		end
	end

	assign hist_shift = {hist_s2, taken_q};
	assign nh = hist_shift[HW-1:0] & hmask;
	assign row_hist_new = global_history_q ? rowh_s2 : nh;
	assign pred = !upd && hit_s2 && (ctr_old >= btb_pkg::CTR_TAKEN_MIN);

	assign row_we = cmd.commit && upd;
	assign sh_we = cmd.commit && upd && global_table_q;
	assign rc_we = (cmd.commit && upd && !global_table_q && hit_s2) || cmd.fill;
	assign rc_waddr = cmd.fill ? {row_q, fill_q} : {row_q, idx_s2};
	assign rc_wdata = (cmd.fill && (fill_q != idx_s2)) ? initial_state_q : stepped;

	btb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_q),
		.wdata ({tag_s2, target_q, row_hist_new}),
		.re    (cmd.accept),
		.raddr (row_in),
		.rdata (row_rd)
	);

	btb_ram #(.WIDTH(2), .DEPTH(CTR_DEPTH)) u_shared_ctr_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (idx_s2),
		.wdata (stepped),
		.re    (cmd.ctr_rd),
		.raddr (idx),
		.rdata (sh_rd)
	);

	btb_ram #(.WIDTH(2), .DEPTH(MAX_ENTRIES * CTR_DEPTH)) u_row_ctr_ram (
		.clk   (clk),
		.we    (rc_we),
		.waddr (rc_waddr),
		.wdata (rc_wdata),
		.re    (cmd.ctr_rd),
		.raddr ({row_q, idx}),
		.rdata (rc_rd)
	);

	// Configuration, table state and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_entries_q <= btb_pkg::RST_LOG2_ENTRIES;
			history_bits_q <= btb_pkg::RST_HISTORY_BITS;
			tag_bits_q <= btb_pkg::RST_TAG_BITS;
			initial_state_q <= btb_pkg::RST_INITIAL_STATE;
			global_history_q <= 1'b0;
			global_table_q <= 1'b0;
			share_mode_q <= btb_pkg::SHARE_NONE;
			row_valid_q <= '0;
			sh_valid_q <= '0;
			shist_q <= '0;
			upd_q <= '0;
			mis_q <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					btb_pkg::REG_LOG2_ENTRIES:   log2_entries_q <= cfg_data[2:0];
					btb_pkg::REG_HISTORY_BITS:   history_bits_q <= cfg_data[3:0];
					btb_pkg::REG_TAG_BITS:       tag_bits_q <= cfg_data;
					btb_pkg::REG_INITIAL_STATE: begin
						initial_state_q <= cfg_data[1:0];
						row_valid_q <= '0;
						sh_valid_q <= '0;
						shist_q <= '0;
					end
					btb_pkg::REG_GLOBAL_HISTORY: global_history_q <= cfg_data[0];
					btb_pkg::REG_GLOBAL_TABLE:   global_table_q <= cfg_data[0];
					btb_pkg::REG_SHARE_MODE:     share_mode_q <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
			if (row_we) begin
				row_valid_q[row_q] <= 1'b1;
				upd_q <= upd_q + 32'd1;
				if (!ok_q) begin
					mis_q <= mis_q + 32'd1;
				end
				if (global_history_q) begin
					shist_q <= nh;
				end
			end
			if (sh_we) begin
				sh_valid_q[idx_s2] <= 1'b1;
			end
		end
	end

	// Item registers and per-item working stages.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			pc_q <= pc;
			target_q <= resolved_pc;
			taken_q <= taken;
			ok_q <= ((guessed_dst == resolved_pc) == taken);
			row_q <= row_in;
		end
		if (cmd.ctr_rd) begin
			hit_s2 <= hit;
			idx_s2 <= idx;
			hist_s2 <= hist_eff;
			rowh_s2 <= hit ? rd_hist : '0;
			tag_s2 <= pc_tag;
			tgt_s2 <= rd_tgt;
		end
		if (cmd.commit) begin
			fill_q <= '0;
			res_taken_q <= pred;
			res_pc_q <= upd ? 32'd0 : (pred ? tgt_s2 : pc_q + 32'(btb_pkg::PC_STEP));
		end else if (cmd.fill) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// Result register toward the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_taken_q <= 1'b0;
			out_pc_q <= '0;
			out_bc_q <= '0;
			out_fc_q <= '0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
			out_taken_q <= res_taken_q;
			out_pc_q <= res_pc_q;
			out_bc_q <= upd_q;
			out_fc_q <= mis_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.need_fill = need_fill;
	assign st.fill_last = (fill_q == {HW{1'b1}});
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign predict_taken = out_taken_q;
	assign next_pc = out_pc_q;
	assign branch_count = out_bc_q;
	assign flush_count = out_fc_q;

endmodule

// ===== rtl/two_level_branch_predictor_btb.sv =====
// Top level of the two-level branch predictor with branch target buffer.
// Usage:
// An input beat carries func, pc, resolved_pc, taken and guessed_dst under
// in_valid/in_ready. A predict beat returns predict_taken and next_pc; an
// update beat trains the buffer and returns zeros there. Every result beat
// also shows branch_count and flush_count under out_valid/out_ready.
// One item is in flight at a time. The row is read at the accepting edge; the
// result is valid after the counter read, the commit and the result load, in
// that order. in_ready returns once the result is loaded, so no new item is
// taken before then. An update that misses while per-row counter tables are
// selected also sweeps all 2**MAX_HISTORY counters of the row, one per cycle,
// before the result load.
// The result sits in an output register; when the receiver stalls, the
// finished item waits before that register and no new beat is taken.
// Reset clears all rows to invalid, the shared counters to the initial state,
// histories and counts to zero, and loads the register reset values.
// Configuration writes are taken on any cycle with cfg_wen high.
`timescale 1ns / 1ps
module two_level_branch_predictor_btb #(
	parameter int MAX_ENTRIES = btb_pkg::DEF_MAX_ENTRIES,
	parameter int MAX_HISTORY = btb_pkg::DEF_MAX_HISTORY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [btb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [btb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [31:0]                     pc,
	input  logic [31:0]                     resolved_pc,
	input  logic                            taken,
	input  logic [31:0]                     guessed_dst,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            predict_taken,
	output logic [31:0]                     next_pc,
	output logic [31:0]                     branch_count,
	output logic [31:0]                     flush_count
);

	btb_pkg::cmd_t    cmd;
	btb_pkg::status_t st;

	btb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	btb_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_HISTORY (MAX_HISTORY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.pc            (pc),
		.resolved_pc   (resolved_pc),
		.taken         (taken),
		.guessed_dst   (guessed_dst),
		.cmd           (cmd),
		.st            (st),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.predict_taken (predict_taken),
		.next_pc       (next_pc),
		.branch_count  (branch_count),
		.flush_count   (flush_count)
	);

endmodule

// ===== rtl/btb_chk.sv =====
// Port-level checker for the branch target buffer and its bind.
`timescale 1ns / 1ps
module btb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] next_pc,
	input logic [31:0] branch_count,
	input logic [31:0] flush_count
);

	// Only one item is in flight, so an accepted beat closes the input side.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item was in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(branch_count))
		else $error("result beat changed while stalled");

	a_count_with_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(branch_count) |-> out_valid)
		else $error("branch count moved without a result beat");

	a_flush_with_branch: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(flush_count) |-> !$stable(branch_count))
		else $error("flush count moved without a counted update");

endmodule

bind two_level_branch_predictor_btb btb_chk u_chk (.*);
